/* design/ibs_pkg.sv */
// Interval break span package: sizes, item types and the table port struct.
// Used by ibs_table, ibs_scan and interval_break_span_unit.
package ibs_pkg;

  localparam int TableDepth = 256;
  localparam int ValueBits  = 32;
  localparam int AddrBits   = $clog2(TableDepth);
  localparam int CountBits  = $clog2(TableDepth + 1);
  localparam int CfgBits    = 9;
  localparam int IndexBits  = 8;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic                        op;
    logic [7:0]                  entry_index;
    logic signed [ValueBits-1:0] break_value;
    logic signed [ValueBits-1:0] low_end;
    logic signed [ValueBits-1:0] high_end;
  } in_item_t;

  typedef struct packed {
    logic [IndexBits-1:0] first_index;
    logic [IndexBits-1:0] last_index;
  } out_item_t;

  typedef struct packed {
    logic                 wr_en;
    logic [AddrBits-1:0]  wr_addr;
    logic [ValueBits-1:0] wr_data;
    logic                 rd_en;
    logic [AddrBits-1:0]  rd_addr;
  } mem_req_t;

endpackage

/* design/interval_break_span_unit.sv */
// Interval break span top level: configuration register, scan sequencer and
// break table. Depends on ibs_pkg, ibs_table and ibs_scan.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i) takes load and query items.
//   A load writes break_value at entry_index and gives no result.
//   A query scans the first break_count entries (capped at the table depth),
//   one table read per cycle through a single range comparator, and returns
//   the first and last index whose break lies in [low_end, high_end], both 0
//   if none.
//   From the acceptance of a query to its result, the input is not ready.
//   Result channel (out_valid_o/out_ready_i, out_item_o) is a register: while
//   the receiver stalls, the block still accepts loads and runs the next query,
//   holding that query's result until the register frees.
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_data_i) writes
//   break_count; it is always ready.
//   Reset clears break_count and the control state; the table is undefined
//   until written and needs no clearing pass.
module interval_break_span_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ibs_pkg::CfgBits-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ibs_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ibs_pkg::out_item_t          out_item_o
);

  logic [ibs_pkg::CfgBits-1:0]   break_count_q;
  ibs_pkg::mem_req_t             mem_req;
  logic [ibs_pkg::ValueBits-1:0] rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      break_count_q <= '0;
    end else if (cfg_valid_i) begin
      break_count_q <= cfg_data_i;
    end
  end

  ibs_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .break_count_i (break_count_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o),
    .mem_req_o     (mem_req),
    .rd_data_i     (rd_data)
  );

  ibs_table u_table (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

/* design/ibs_table.sv */
// Break table memory: one write and one read port, registered read data.
// Depends on ibs_pkg for depth, width and the request struct.
module ibs_table (
  input  logic                          clk_i,
  input  ibs_pkg::mem_req_t             req_i,
  output logic [ibs_pkg::ValueBits-1:0] rd_data_o
);

  logic [ibs_pkg::ValueBits-1:0] mem [ibs_pkg::TableDepth];
  logic [ibs_pkg::ValueBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/ibs_scan.sv */
// Scan sequencer: accepts items, writes loads to the table and walks the table
// for queries with one shared range comparator. Depends on ibs_pkg.
module ibs_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ibs_pkg::CfgBits-1:0]   break_count_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ibs_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ibs_pkg::out_item_t            out_item_o,
  output ibs_pkg::mem_req_t             mem_req_o,
  input  logic [ibs_pkg::ValueBits-1:0] rd_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e                              state_q, state_d;
  logic [ibs_pkg::CountBits-1:0]       cnt_q, cnt_d;
  logic [ibs_pkg::CountBits-1:0]       limit_q, limit_d;
  logic                                pend_q, pend_d;
  logic [ibs_pkg::AddrBits-1:0]        pend_idx_q, pend_idx_d;
  logic                                found_q, found_d;
  logic [ibs_pkg::AddrBits-1:0]        first_q, first_d;
  logic [ibs_pkg::AddrBits-1:0]        last_q, last_d;
  logic signed [ibs_pkg::ValueBits-1:0] lo_q, lo_d;
  logic signed [ibs_pkg::ValueBits-1:0] hi_q, hi_d;
  logic                                out_valid_q, out_valid_d;
  ibs_pkg::out_item_t                  out_item_q, out_item_d;
  logic                                in_acc;
  logic                                hit;
  logic signed [ibs_pkg::ValueBits-1:0] rd_val;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_val     = $signed(rd_data_i);
  assign hit        = (rd_val >= lo_q) && (rd_val <= hi_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    found_d     = found_q;
    first_d     = first_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    mem_req_o.wr_en   = 1'b0;
    mem_req_o.wr_addr = ibs_pkg::AddrBits'(in_item_i.entry_index);
    mem_req_o.wr_data = in_item_i.break_value;
    mem_req_o.rd_en   = 1'b0;
    mem_req_o.rd_addr = cnt_q[ibs_pkg::AddrBits-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_item_i.op == ibs_pkg::OpLoad) begin
            mem_req_o.wr_en = (int'(in_item_i.entry_index) < ibs_pkg::TableDepth);
          end else begin
            lo_d    = in_item_i.low_end;
            hi_d    = in_item_i.high_end;
            cnt_d   = '0;
            found_d = 1'b0;
            first_d = '0;
            last_d  = '0;
            limit_d = (int'(break_count_i) > ibs_pkg::TableDepth) ?
                      ibs_pkg::CountBits'(ibs_pkg::TableDepth) :
                      ibs_pkg::CountBits'(break_count_i);
            state_d = StScan;
          end
        end
      end
      StScan: begin
        // issue the next read while comparing the previous one
        if (cnt_q < limit_q) begin
          mem_req_o.rd_en = 1'b1;
          pend_d          = 1'b1;
          pend_idx_d      = cnt_q[ibs_pkg::AddrBits-1:0];
          cnt_d           = cnt_q + 1'b1;
        end else if (!pend_q) begin
          state_d = StDone;
        end
        if (pend_q && hit) begin
          if (!found_q) begin
            first_d = pend_idx_q;
          end
          found_d = 1'b1;
          last_d  = pend_idx_q;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_item_d.first_index = ibs_pkg::IndexBits'(first_q);
          out_item_d.last_index  = ibs_pkg::IndexBits'(last_q);
          state_d                = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      limit_q     <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      limit_q     <= limit_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    first_q    <= first_d;
    last_q     <= last_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= limit_q)
    else $error("scan count passed its limit");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == StScan)
    else $error("read pending outside a scan");

  a_load_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.op == ibs_pkg::OpLoad |=> state_q == StIdle)
    else $error("load item started a scan");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone && found_q |-> first_q <= last_q)
    else $error("first index above last index");

endmodule

/* tb/ibs_span_check_pkg.sv */
// Span checker for the interval break span testbench: mirrors the break table
// and the scanned count, predicts each query's first and last index and checks
// results in order. Depends on ibs_pkg.
package ibs_span_check_pkg;
  import ibs_pkg::*;

  class span_scoreboard;
    logic signed [ValueBits-1:0] breaks [TableDepth];
    int                          scan_len;
    out_item_t                   spans_due [$];
    int unsigned                 errors;

    function new();
      foreach (breaks[i]) breaks[i] = '0;
      scan_len = 0;
      errors = 0;
    endfunction

    function void set_count(logic [CfgBits-1:0] count);
      scan_len = (count > TableDepth) ? TableDepth : int'(count);
    endfunction

    function out_item_t predict_span(logic signed [ValueBits-1:0] lo,
                                     logic signed [ValueBits-1:0] hi);
      out_item_t span;
      bit        found;
      span = '0;
      found = 1'b0;
      for (int j = 0; j < scan_len; j++) begin
        if (lo <= breaks[j] && breaks[j] <= hi) begin
          if (!found) span.first_index = IndexBits'(j);
          found = 1'b1;
          span.last_index = IndexBits'(j);
        end
      end
      return span;
    endfunction

    function void note_input(in_item_t item);
      if (item.op == OpLoad) begin
        breaks[item.entry_index] = item.break_value;
      end else begin
        spans_due.push_back(predict_span(item.low_end, item.high_end));
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (spans_due.size() == 0) begin
        report($sformatf("result with none due: first %0d last %0d",
                         got.first_index, got.last_index));
        return;
      end
      want = spans_due.pop_front();
      if (got.first_index !== want.first_index) begin
        report($sformatf("first_index %0d, want %0d", got.first_index, want.first_index));
      end
      if (got.last_index !== want.last_index) begin
        report($sformatf("last_index %0d, want %0d", got.last_index, want.last_index));
      end
    endtask

    function int pending();
      return spans_due.size();
    endfunction
  endclass

endpackage

/* tb/testbench.sv */
// Testbench for interval_break_span_unit: loads the break table, sweeps the
// scanned count and checks every query result against span_scoreboard.
// Depends on ibs_pkg, ibs_span_check_pkg and the interval break span RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ibs_pkg::*;
  import ibs_span_check_pkg::*;

  localparam int SettleCycles = 8;
  localparam int StallLimit   = 4000;
  localparam int PhaseItems   = 120;
  localparam int LongHold     = 600;
  localparam logic signed [ValueBits-1:0] MinValue = {1'b1, {(ValueBits-1){1'b0}}};
  localparam logic signed [ValueBits-1:0] MaxValue = {1'b0, {(ValueBits-1){1'b1}}};

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgBits-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;

  span_scoreboard spans = new();
  int             rx_hold = 0;
  bit             rx_eager = 1'b0;
  bit             tx_eager = 1'b0;
  int             idle_cycles = 0;

  interval_break_span_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int rx_wait;
    rx_wait = 0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready) begin
        spans.check_result(out_item);
        if ($urandom_range(0, 31) == 0) rx_eager = !rx_eager;
        rx_wait = rx_eager ? 0 : $urandom_range(0, 15);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_count(input logic [CfgBits-1:0] count);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    spans.set_count(count);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input in_item_t item);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    spans.note_input(item);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (spans.pending() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic signed [ValueBits-1:0] clamp_value(longint v);
    if (v < longint'(MinValue)) return MinValue;
    if (v > longint'(MaxValue)) return MaxValue;
    return v[ValueBits-1:0];
  endfunction

  function automatic logic signed [ValueBits-1:0] pick_break();
    int k;
    k = $urandom_range(0, 64);
    case ($urandom_range(0, 9))
      0: return MinValue;
      1: return MaxValue;
      2, 3: return $urandom;
      default: return ValueBits'((k - 32) * 16384);
    endcase
  endfunction

  function automatic in_item_t load_of(int idx, logic signed [ValueBits-1:0] value);
    in_item_t item;
    item.op          = OpLoad;
    item.entry_index = IndexBits'(idx);
    item.break_value = value;
    item.low_end     = $urandom;
    item.high_end    = $urandom;
    return item;
  endfunction

  function automatic in_item_t query_of(logic signed [ValueBits-1:0] lo,
                                        logic signed [ValueBits-1:0] hi);
    in_item_t item;
    item.op          = OpQuery;
    item.entry_index = IndexBits'($urandom);
    item.break_value = $urandom;
    item.low_end     = lo;
    item.high_end    = hi;
    return item;
  endfunction

  function automatic in_item_t make_load();
    int n;
    int idx;
    n = spans.scan_len;
    idx = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                 : $urandom_range(0, TableDepth - 1);
    return load_of(idx, pick_break());
  endfunction

  function automatic in_item_t make_query();
    logic signed [ValueBits-1:0] a;
    logic signed [ValueBits-1:0] b;
    logic signed [ValueBits-1:0] t;
    int n;
    int d;
    int e;
    n = spans.scan_len;
    d = $urandom_range(0, 3);
    e = $urandom_range(0, 3);
    a = (n > 0) ? spans.breaks[$urandom_range(0, n - 1)] : pick_break();
    b = (n > 0) ? spans.breaks[$urandom_range(0, n - 1)] : pick_break();
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return query_of(clamp_value(longint'(a) - d),
                                     clamp_value(longint'(b) + e));
      5: return query_of(a, a);
      6: return query_of($urandom, $urandom);
      7: return query_of(b, clamp_value(longint'(a) - 1 - d));
      8: return query_of(pick_break(), MaxValue);
      default: return query_of(MinValue, MaxValue);
    endcase
  endfunction

  initial begin
    int order [TableDepth];
    int counts [12];
    int j;
    int t;
    counts = '{256, 2, 9, 511, 1, 37, 5, 120, 3, 17, 256, 0};
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_count('0);
    send_item(query_of(MinValue, MaxValue));
    foreach (order[i]) order[i] = i;
    for (int i = TableDepth - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) begin
      send_item(load_of(order[i], pick_break()));
      if ($urandom_range(0, 3) == 0) send_item(make_query());
    end
    drain();

    write_count(CfgBits'(4));
    send_item(load_of(0, MinValue));
    send_item(load_of(1, MaxValue));
    send_item(load_of(2, 0));
    send_item(load_of(3, -1));
    send_item(query_of(MinValue, MaxValue));
    send_item(query_of(1, -1));
    send_item(query_of(0, 0));
    send_item(query_of(-1, -1));
    send_item(query_of(MinValue, MinValue));
    send_item(query_of(MinValue + 1, MaxValue - 1));
    send_item(query_of(1, MaxValue - 1));
    send_item(query_of(MinValue, -1));
    send_item(load_of(TableDepth - 1, MaxValue));
    drain();
    write_count('1);
    send_item(query_of(MinValue, MaxValue));
    send_item(query_of(MaxValue, MaxValue));
    drain();

    foreach (counts[p]) begin
      write_count(CfgBits'(counts[p]));
      tx_eager = ($urandom_range(0, 2) == 0);
      if (p == 2) rx_hold = LongHold;
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 5 && n == PhaseItems / 2) drain();
        send_item(($urandom_range(0, 99) < 45) ? make_query() : make_load());
      end
      drain();
    end

    if (spans.pending() != 0) spans.report("results still due at end of run");
    if (spans.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
